### hw/rtl/lmtb_pkg.sv
`timescale 1ns / 1ps

package lmtb_pkg;

    localparam int ADDR_W = 5;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [12:0] frame_height;
        logic [3:0]  window_half;
        logic [7:0]  k_q8;
        logic [7:0]  assumed_std;
        logic [7:0]  dark_floor;
    } cfg_t;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_FRAME_WIDTH  = 3'd0;
    localparam reg_idx_t REG_FRAME_HEIGHT = 3'd1;
    localparam reg_idx_t REG_WINDOW_HALF  = 3'd2;
    localparam reg_idx_t REG_K_Q8         = 3'd3;
    localparam reg_idx_t REG_ASSUMED_STD  = 3'd4;
    localparam reg_idx_t REG_DARK_FLOOR   = 3'd5;

    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [3:0]  WINDOW_HALF_RST  = 4'd7;
    localparam logic [7:0]  K_Q8_RST         = 8'd128;
    localparam logic [7:0]  ASSUMED_STD_RST  = 8'd20;
    localparam logic [7:0]  DARK_FLOOR_RST   = 8'd60;

    localparam logic signed [18:0] F_BASE  = 19'sd32768;
    localparam logic signed [9:0]  STD_MID = 10'sd128;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef enum logic [0:0] {
        F_RUN,
        F_SYNC
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PREP,
        B_SUM,
        B_DRAIN,
        B_MUL,
        B_RD,
        B_WAIT,
        B_OUT
    } back_state_t;

endpackage

### hw/rtl/lmtb_queue.sv
`timescale 1ns / 1ps

module lmtb_queue #(
    parameter int W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [W-1:0]      push_data,
    input  logic              pop,
    output logic [W-1:0]      pop_data,
    output lmtb_pkg::q_stat_t q_stat
);

    logic [W-1:0] entry_reg [0:1];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == 2'd0);
    assign q_stat.full  = (count_reg == 2'd2);

endmodule

### hw/rtl/lmtb_front.sv
`timescale 1ns / 1ps

module lmtb_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HALF   = 8,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW     = $clog2(MAX_WIDTH),
    localparam int RW     = $clog2(MAX_HEIGHT),
    localparam int SLOT_W = $clog2(2 * MAX_HALF),
    localparam int JW     = 3 * (RW + CW)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lmtb_pkg::cfg_t         cfg,
    input  logic                   half_wr,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_pixel,
    input  lmtb_pkg::q_stat_t      q_stat,
    input  logic                   back_busy,
    output logic                   job_push,
    output logic [JW-1:0]          job_data,
    output logic                   mem_we,
    output logic [SLOT_W+CW-1:0]   mem_waddr,
    output logic [7:0]             mem_wdata
);

    localparam int NB  = (RW > CW) ? RW : CW;
    localparam int NCW = $clog2(NB + 1);

    lmtb_pkg::front_state_t state_reg, state_next;

    logic [RW-1:0]  row_reg;
    logic [CW-1:0]  col_reg;
    logic [3:0]     rph_reg;
    logic [3:0]     cph_reg;
    logic [RW-1:0]  last_r_reg;
    logic [CW-1:0]  last_c_reg;
    logic [NB-1:0]  sh_r_reg;
    logic [NB-1:0]  sh_c_reg;
    logic [3:0]     rem_r_reg;
    logic [3:0]     rem_c_reg;
    logic [NCW-1:0] sync_cnt_reg;

    logic [CW:0]    eff_w;
    logic [RW:0]    eff_hgt;
    logic [3:0]     eff_h;
    logic [RW:0]    r0, rn;
    logic [CW:0]    c0, cn;
    logic [3:0]     rp0, cp0, rpn, cpn;
    logic           trig;
    logic [RW-1:0]  ty, y0;
    logic [CW-1:0]  tx, x0;
    logic           hz_ok;
    logic           accept;
    logic           sync_last;
    logic [4:0]     t_r, t_c;
    logic [3:0]     rem_r_next, rem_c_next;

    function automatic logic [3:0] adv(input logic [3:0] p, input logic [3:0] h);
        adv = (p + 4'd1 == h) ? 4'd0 : p + 4'd1;
    endfunction

    always_comb begin
        if (cfg.frame_width == '0) begin
            eff_w = (CW+1)'(1);
        end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = (CW+1)'(MAX_WIDTH);
        end else begin
            eff_w = (CW+1)'(cfg.frame_width);
        end
        if (cfg.frame_height == '0) begin
            eff_hgt = (RW+1)'(1);
        end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
            eff_hgt = (RW+1)'(MAX_HEIGHT);
        end else begin
            eff_hgt = (RW+1)'(cfg.frame_height);
        end
        if (cfg.window_half == '0) begin
            eff_h = 4'd1;
        end else if (32'(cfg.window_half) > 32'(MAX_HALF)) begin
            eff_h = 4'(MAX_HALF);
        end else begin
            eff_h = cfg.window_half;
        end
    end

    always_comb begin
        r0  = {1'b0, row_reg};
        c0  = {1'b0, col_reg};
        rp0 = rph_reg;
        cp0 = cph_reg;
        if (c0 >= eff_w) begin
            c0  = '0;
            cp0 = '0;
            r0  = r0 + 1'b1;
            rp0 = adv(rp0, eff_h);
        end
        if (r0 >= eff_hgt) begin
            r0  = '0;
            rp0 = '0;
        end
        trig = ((rp0 + 4'd1 == eff_h) || (r0 + 1'b1 == eff_hgt)) &&
               ((cp0 + 4'd1 == eff_h) || (c0 + 1'b1 == eff_w));
        cn  = c0 + 1'b1;
        rn  = r0;
        cpn = adv(cp0, eff_h);
        rpn = rp0;
        if (cn >= eff_w) begin
            cn  = '0;
            cpn = '0;
            rn  = r0 + 1'b1;
            rpn = adv(rp0, eff_h);
            if (rn >= eff_hgt) begin
                rn  = '0;
                rpn = '0;
            end
        end
    end

    always_comb begin
        ty = r0[RW-1:0] - RW'(rp0);
        tx = c0[CW-1:0] - CW'(cp0);
        y0 = (ty >= RW'(eff_h)) ? ty - RW'(eff_h) : '0;
        x0 = (tx >= CW'(eff_h)) ? tx - CW'(eff_h) : '0;
        hz_ok = (q_stat.empty && !back_busy) ||
                (r0[RW-1:0] == last_r_reg && c0[CW-1:0] > last_c_reg);
    end

    always_comb begin
        t_r = {rem_r_reg, sh_r_reg[NB-1]};
        t_c = {rem_c_reg, sh_c_reg[NB-1]};
        if (t_r >= {1'b0, eff_h}) begin
            t_r = t_r - {1'b0, eff_h};
        end
        if (t_c >= {1'b0, eff_h}) begin
            t_c = t_c - {1'b0, eff_h};
        end
        rem_r_next = t_r[3:0];
        rem_c_next = t_c[3:0];
        sync_last  = (sync_cnt_reg == NCW'(NB - 1));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lmtb_pkg::F_RUN: begin
                if (half_wr) begin
                    state_next = lmtb_pkg::F_SYNC;
                end
            end
            lmtb_pkg::F_SYNC: begin
                if (half_wr) begin
                    state_next = lmtb_pkg::F_SYNC;
                end else if (sync_last) begin
                    state_next = lmtb_pkg::F_RUN;
                end
            end
            default: state_next = lmtb_pkg::F_RUN;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        case (state_reg)
            lmtb_pkg::F_RUN:  s_ready = !half_wr && !q_stat.full && hz_ok;
            lmtb_pkg::F_SYNC: s_ready = 1'b0;
            default:          s_ready = 1'b0;
        endcase
        accept    = s_valid && s_ready;
        job_push  = accept && trig;
        job_data  = {r0[RW-1:0], c0[CW-1:0], ty, tx, y0, x0};
        mem_we    = accept;
        mem_waddr = {r0[SLOT_W-1:0], c0[CW-1:0]};
        mem_wdata = s_pixel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lmtb_pkg::F_RUN;
            row_reg      <= '0;
            col_reg      <= '0;
            rph_reg      <= '0;
            cph_reg      <= '0;
            last_r_reg   <= '0;
            last_c_reg   <= '0;
            sh_r_reg     <= '0;
            sh_c_reg     <= '0;
            rem_r_reg    <= '0;
            rem_c_reg    <= '0;
            sync_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (half_wr) begin
                sh_r_reg     <= NB'(row_reg);
                sh_c_reg     <= NB'(col_reg);
                rem_r_reg    <= '0;
                rem_c_reg    <= '0;
                sync_cnt_reg <= '0;
            end else if (state_reg == lmtb_pkg::F_SYNC) begin
                sh_r_reg     <= sh_r_reg << 1;
                sh_c_reg     <= sh_c_reg << 1;
                rem_r_reg    <= rem_r_next;
                rem_c_reg    <= rem_c_next;
                sync_cnt_reg <= sync_cnt_reg + 1'b1;
                if (sync_last) begin
                    rph_reg <= rem_r_next;
                    cph_reg <= rem_c_next;
                end
            end
            if (accept) begin
                row_reg <= rn[RW-1:0];
                col_reg <= cn[CW-1:0];
                rph_reg <= rpn;
                cph_reg <= cpn;
            end
            if (job_push) begin
                last_r_reg <= r0[RW-1:0];
                last_c_reg <= c0[CW-1:0];
            end
        end
    end

endmodule

### hw/rtl/lmtb_back.sv
`timescale 1ns / 1ps

module lmtb_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HALF   = 8,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW     = $clog2(MAX_WIDTH),
    localparam int RW     = $clog2(MAX_HEIGHT),
    localparam int SLOT_W = $clog2(2 * MAX_HALF),
    localparam int JW     = 3 * (RW + CW)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lmtb_pkg::cfg_t       cfg,
    input  lmtb_pkg::q_stat_t    q_stat,
    input  logic [JW-1:0]        job_data,
    output logic                 pop,
    output logic                 back_busy,
    input  logic                 mem_we,
    input  logic [SLOT_W+CW-1:0] mem_waddr,
    input  logic [7:0]           mem_wdata,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [RW-1:0]        m_out_row,
    output logic [CW-1:0]        m_out_col,
    output logic                 m_white,
    output logic                 m_tile_last
);

    localparam int DEPTH = 1 << (SLOT_W + CW);

    lmtb_pkg::back_state_t state_reg, state_next;

    logic [7:0] band_mem [0:DEPTH-1];

    logic [RW-1:0] r_reg, ty_reg, y0_reg, yy_reg;
    logic [CW-1:0] c_reg, tx_reg, x0_reg, xx_reg;
    logic [15:0]   sum_reg;
    logic [15:0]   f_reg;
    logic [8:0]    cnt_reg;
    logic [31:0]   rhs_reg;
    logic [16:0]   vc_reg;
    logic          gt_reg;
    logic [7:0]    rd_data_reg;
    logic          rd_pend_reg;
    logic          m_valid_reg;
    logic [RW-1:0] m_row_reg;
    logic [CW-1:0] m_col_reg;
    logic          m_white_reg;
    logic          m_last_reg;

    logic [RW-1:0]          j_r, j_ty, j_y0;
    logic [CW-1:0]          j_c, j_tx, j_x0;
    logic                   rd_en;
    logic [SLOT_W+CW-1:0]   rd_addr;
    logic                   out_free;
    logic                   row_end, win_end;
    logic signed [18:0]     kprod, fsum;
    logic [4:0]             rows5, cols5;
    logic [9:0]             cnt_w;
    logic [31:0]            rhs_w;
    logic [16:0]            vc_w;
    logic                   white_w;

    assign {j_r, j_c, j_ty, j_tx, j_y0, j_x0} = job_data;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        row_end  = (xx_reg == c_reg);
        win_end  = row_end && (yy_reg == r_reg);
        kprod    = $signed({1'b0, cfg.k_q8}) *
                   ($signed({2'b00, cfg.assumed_std}) - lmtb_pkg::STD_MID);
        fsum     = lmtb_pkg::F_BASE + kprod;
        rows5    = 5'(r_reg - y0_reg + 1'b1);
        cols5    = 5'(c_reg - x0_reg + 1'b1);
        cnt_w    = rows5 * cols5;
        rhs_w    = sum_reg * f_reg;
        vc_w     = rd_data_reg * cnt_reg;
        white_w  = gt_reg && ({vc_reg, 15'b0} > rhs_reg);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lmtb_pkg::B_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = lmtb_pkg::B_PREP;
                end
            end
            lmtb_pkg::B_PREP:  state_next = lmtb_pkg::B_SUM;
            lmtb_pkg::B_SUM: begin
                if (win_end) begin
                    state_next = lmtb_pkg::B_DRAIN;
                end
            end
            lmtb_pkg::B_DRAIN: state_next = lmtb_pkg::B_MUL;
            lmtb_pkg::B_MUL:   state_next = lmtb_pkg::B_RD;
            lmtb_pkg::B_RD:    state_next = lmtb_pkg::B_WAIT;
            lmtb_pkg::B_WAIT:  state_next = lmtb_pkg::B_OUT;
            lmtb_pkg::B_OUT: begin
                if (out_free) begin
                    state_next = win_end ? lmtb_pkg::B_IDLE : lmtb_pkg::B_RD;
                end
            end
            default: state_next = lmtb_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        back_busy = 1'b1;
        case (state_reg)
            lmtb_pkg::B_IDLE: begin
                pop       = !q_stat.empty;
                back_busy = 1'b0;
            end
            lmtb_pkg::B_SUM: rd_en = 1'b1;
            lmtb_pkg::B_RD:  rd_en = 1'b1;
            default: begin
                rd_en = 1'b0;
            end
        endcase
        rd_addr = {yy_reg[SLOT_W-1:0], xx_reg};
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            band_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= band_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            lmtb_pkg::B_IDLE: begin
                if (!q_stat.empty) begin
                    r_reg   <= j_r;
                    c_reg   <= j_c;
                    ty_reg  <= j_ty;
                    tx_reg  <= j_tx;
                    y0_reg  <= j_y0;
                    x0_reg  <= j_x0;
                    yy_reg  <= j_y0;
                    xx_reg  <= j_x0;
                    sum_reg <= '0;
                end
            end
            lmtb_pkg::B_PREP: begin
                f_reg   <= fsum[15:0];
                cnt_reg <= cnt_w[8:0];
            end
            lmtb_pkg::B_SUM: begin
                if (rd_pend_reg) begin
                    sum_reg <= sum_reg + 16'(rd_data_reg);
                end
                if (row_end) begin
                    xx_reg <= x0_reg;
                    yy_reg <= yy_reg + 1'b1;
                end else begin
                    xx_reg <= xx_reg + 1'b1;
                end
            end
            lmtb_pkg::B_DRAIN: begin
                sum_reg <= sum_reg + 16'(rd_data_reg);
            end
            lmtb_pkg::B_MUL: begin
                rhs_reg <= rhs_w;
                yy_reg  <= ty_reg;
                xx_reg  <= tx_reg;
            end
            lmtb_pkg::B_WAIT: begin
                vc_reg <= vc_w;
                gt_reg <= rd_data_reg > cfg.dark_floor;
            end
            lmtb_pkg::B_OUT: begin
                if (out_free) begin
                    m_row_reg   <= yy_reg;
                    m_col_reg   <= xx_reg;
                    m_white_reg <= white_w;
                    m_last_reg  <= win_end;
                    if (row_end) begin
                        xx_reg <= tx_reg;
                        yy_reg <= yy_reg + 1'b1;
                    end else begin
                        xx_reg <= xx_reg + 1'b1;
                    end
                end
            end
            default: begin
                rhs_reg <= rhs_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lmtb_pkg::B_IDLE;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;
            if (state_reg == lmtb_pkg::B_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_white     = m_white_reg;
    assign m_tile_last = m_last_reg;

endmodule

### hw/rtl/local_mean_tile_binarizer.sv
`timescale 1ns / 1ps
// Tiled local-mean binarizer with a fixed assumed deviation.
// Input: one 8-bit grey pixel per s_valid/s_ready transfer, raster order.
// Output: one binarized pixel per m_valid/m_ready transfer with its row and
// column; m_tile_last marks the last pixel of a tile. Tiles come out whole,
// in raster order inside the tile, once their bottom-right pixel arrives.
// Geometry, k, assumed deviation and dark floor sit in an APB register
// file at byte addresses 0, 4, 8, 12, 16, 20.
// Throughput: one pixel per cycle between tile corners while intake is not
// stalled as below. A corner pixel queues a tile job; the tile engine sums
// the clipped window in PREP, SUM and DRAIN (one band-memory read per cycle)
// and forms the threshold in MUL; each tile pixel then passes RD, WAIT, OUT.
// Intake keeps running while jobs are pending as long as the pixel lies on
// the same row after the last queued corner; otherwise it waits.
// A window_half write stalls intake for a resync over max(row, column) bits.
// A stalled receiver holds the output register and the tile engine; intake
// then stops once the two-entry job queue fills.
// Reset loads the register defaults and restarts at row 0, column 0.

module local_mean_tile_binarizer #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HALF   = 8,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW     = $clog2(MAX_WIDTH),
    localparam int RW     = $clog2(MAX_HEIGHT),
    localparam int SLOT_W = $clog2(2 * MAX_HALF),
    localparam int JW     = 3 * (RW + CW)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lmtb_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_pixel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [RW-1:0]                 m_out_row,
    output logic [CW-1:0]                 m_out_col,
    output logic                          m_white,
    output logic                          m_tile_last
);

    lmtb_pkg::cfg_t     cfg_reg;
    lmtb_pkg::reg_idx_t idx;
    lmtb_pkg::q_stat_t  q_stat;
    logic               wr_en;
    logic               half_wr;
    logic               back_busy;
    logic               job_push;
    logic               pop;
    logic [JW-1:0]      job_in;
    logic [JW-1:0]      job_out;
    logic               mem_we;
    logic [SLOT_W+CW-1:0] mem_waddr;
    logic [7:0]         mem_wdata;

    assign idx     = paddr[4:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign half_wr = wr_en && (idx == lmtb_pkg::REG_WINDOW_HALF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= lmtb_pkg::FRAME_WIDTH_RST;
            cfg_reg.frame_height <= lmtb_pkg::FRAME_HEIGHT_RST;
            cfg_reg.window_half  <= lmtb_pkg::WINDOW_HALF_RST;
            cfg_reg.k_q8         <= lmtb_pkg::K_Q8_RST;
            cfg_reg.assumed_std  <= lmtb_pkg::ASSUMED_STD_RST;
            cfg_reg.dark_floor   <= lmtb_pkg::DARK_FLOOR_RST;
        end else if (wr_en) begin
            case (idx)
                lmtb_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[10:0];
                lmtb_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[12:0];
                lmtb_pkg::REG_WINDOW_HALF:  cfg_reg.window_half  <= pwdata[3:0];
                lmtb_pkg::REG_K_Q8:         cfg_reg.k_q8         <= pwdata[7:0];
                lmtb_pkg::REG_ASSUMED_STD:  cfg_reg.assumed_std  <= pwdata[7:0];
                lmtb_pkg::REG_DARK_FLOOR:   cfg_reg.dark_floor   <= pwdata[7:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            lmtb_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_reg.frame_width);
            lmtb_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_reg.frame_height);
            lmtb_pkg::REG_WINDOW_HALF:  prdata = 32'(cfg_reg.window_half);
            lmtb_pkg::REG_K_Q8:         prdata = 32'(cfg_reg.k_q8);
            lmtb_pkg::REG_ASSUMED_STD:  prdata = 32'(cfg_reg.assumed_std);
            lmtb_pkg::REG_DARK_FLOOR:   prdata = 32'(cfg_reg.dark_floor);
            default:                    prdata = '0;
        endcase
    end

    lmtb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HALF   (MAX_HALF),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .half_wr   (half_wr),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .q_stat    (q_stat),
        .back_busy (back_busy),
        .job_push  (job_push),
        .job_data  (job_in),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    lmtb_queue #(
        .W (JW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_in),
        .pop       (pop),
        .pop_data  (job_out),
        .q_stat    (q_stat)
    );

    lmtb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HALF   (MAX_HALF),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_stat      (q_stat),
        .job_data    (job_out),
        .pop         (pop),
        .back_busy   (back_busy),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_white     (m_white),
        .m_tile_last (m_tile_last)
    );

endmodule
